FILE: sv/qtea_pkg.sv
// Shared constants, codes and types of the quaternion to Euler angle converter.
package qtea_pkg;

  // Products and rotation-matrix terms carry 30 fraction bits.
  localparam int FRAC_W = 30;
  localparam int PROD_W = 35;
  localparam int TERM_W = 37;

  // Square root of 2^60 - r21^2, two result bits per pipeline stage.
  localparam int SQ_W = 62;
  localparam int ROOT_STEPS = 31;
  localparam int ROOT_PER_STAGE = 2;
  localparam int ROOT_STAGES = (ROOT_STEPS + ROOT_PER_STAGE - 1) / ROOT_PER_STAGE;
  localparam int SQRT_LAT = ROOT_STAGES + 2;

  // CORDIC datapath; angles accumulate in units where 2^31 is pi.
  localparam int CORD_W = 40;
  localparam int ZACC_W = 34;
  localparam int ZUNIT_W = 32;

  localparam int SEQ_W = 3;
  localparam logic [SEQ_W-1:0] SEQ_ZYX = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_ZXY = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_YXZ = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_YZX = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_XYZ = 3'd4;
  localparam logic [SEQ_W-1:0] SEQ_XZY = 3'd5;

  // atan(2^-i), pi = 2^31.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [TERM_W-1:0] r11;
    logic signed [TERM_W-1:0] r12;
    logic signed [TERM_W-1:0] r21;
    logic signed [TERM_W-1:0] r31;
    logic signed [TERM_W-1:0] r32;
  } terms_t;

endpackage

FILE: sv/qtea_if.sv
// Valid/ready channel interfaces for quaternions, angle triples and the sequence register.
interface qtea_quat_if #(parameter int QUAT_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qtea_angle_if #(parameter int ANGLE_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [ANGLE_WIDTH-1:0] angle_third_axis;
  logic signed [ANGLE_WIDTH-1:0] angle_second_axis;
  logic signed [ANGLE_WIDTH-1:0] angle_first_axis;
  modport source(output valid, angle_third_axis, angle_second_axis, angle_first_axis,
                 input ready);
  modport sink(input valid, angle_third_axis, angle_second_axis, angle_first_axis,
               output ready);
endinterface

interface qtea_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] rotation_sequence;
  modport source(output valid, rotation_sequence, input ready);
  modport sink(input valid, rotation_sequence, output ready);
endinterface

FILE: sv/qtea_terms.sv
// Two-stage rotation-matrix term generator: ten products, then sequence-dependent sums.
module qtea_terms #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [qtea_pkg::SEQ_W-1:0]   seq_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_w_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_x_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_y_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_z_i,
  output qtea_pkg::terms_t             terms_o
);
  import qtea_pkg::*;

  localparam int NPROD = 10;
  localparam int SHIFT = 2 * (QUAT_WIDTH - 2) - FRAC_W;
  localparam int P_WW = 0, P_XX = 1, P_YY = 2, P_ZZ = 3, P_WX = 4;
  localparam int P_WY = 5, P_WZ = 6, P_XY = 7, P_XZ = 8, P_YZ = 9;

  logic signed [QUAT_WIDTH-1:0] opa [NPROD];
  logic signed [QUAT_WIDTH-1:0] opb [NPROD];
  logic signed [PROD_W-1:0]     prod_q [NPROD];
  terms_t                       terms_d, terms_q;

  assign opa = '{quat_w_i, quat_x_i, quat_y_i, quat_z_i, quat_w_i,
                 quat_w_i, quat_w_i, quat_x_i, quat_x_i, quat_y_i};
  assign opb = '{quat_w_i, quat_x_i, quat_y_i, quat_z_i, quat_x_i,
                 quat_y_i, quat_z_i, quat_y_i, quat_z_i, quat_z_i};

  for (genvar k = 0; k < NPROD; k++) begin : g_prod
    logic signed [2*QUAT_WIDTH-1:0] raw;
    logic signed [PROD_W-1:0]       norm;
    assign raw = opa[k] * opb[k];
    // Bring every product to 30 fraction bits; a right shift rounds toward minus infinity.
    if (SHIFT > 0) begin : g_right
      logic signed [2*QUAT_WIDTH-1:0] shifted;
      assign shifted = raw >>> SHIFT;
      assign norm = PROD_W'(shifted);
    end else begin : g_left
      assign norm = PROD_W'(raw) <<< (-SHIFT);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) prod_q[k] <= norm;
    end
  end

  always_comb begin
    logic signed [TERM_W-1:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz, ta, tb, tc;
    ww = TERM_W'(prod_q[P_WW]);
    xx = TERM_W'(prod_q[P_XX]);
    yy = TERM_W'(prod_q[P_YY]);
    zz = TERM_W'(prod_q[P_ZZ]);
    wx = TERM_W'(prod_q[P_WX]);
    wy = TERM_W'(prod_q[P_WY]);
    wz = TERM_W'(prod_q[P_WZ]);
    xy = TERM_W'(prod_q[P_XY]);
    xz = TERM_W'(prod_q[P_XZ]);
    yz = TERM_W'(prod_q[P_YZ]);
    ta = ww + xx - yy - zz;
    tb = ww - xx + yy - zz;
    tc = ww - xx - yy + zz;
    unique case (seq_i)
      SEQ_ZXY: begin
        terms_d.r11 = (wz - xy) <<< 1; terms_d.r12 = tb; terms_d.r21 = (yz + wx) <<< 1;
        terms_d.r31 = (wy - xz) <<< 1; terms_d.r32 = tc;
      end
      SEQ_YXZ: begin
        terms_d.r11 = (xz + wy) <<< 1; terms_d.r12 = tc; terms_d.r21 = (wx - yz) <<< 1;
        terms_d.r31 = (xy + wz) <<< 1; terms_d.r32 = tb;
      end
      SEQ_YZX: begin
        terms_d.r11 = (wy - xz) <<< 1; terms_d.r12 = ta; terms_d.r21 = (xy + wz) <<< 1;
        terms_d.r31 = (wx - yz) <<< 1; terms_d.r32 = tb;
      end
      SEQ_XYZ: begin
        terms_d.r11 = (wx - yz) <<< 1; terms_d.r12 = tc; terms_d.r21 = (xz + wy) <<< 1;
        terms_d.r31 = (wz - xy) <<< 1; terms_d.r32 = ta;
      end
      SEQ_XZY: begin
        terms_d.r11 = (yz + wx) <<< 1; terms_d.r12 = tb; terms_d.r21 = (wz - xy) <<< 1;
        terms_d.r31 = (xz + wy) <<< 1; terms_d.r32 = ta;
      end
      default: begin
        // zyx, and the unused codes decode the same way.
        terms_d.r11 = (xy + wz) <<< 1; terms_d.r12 = ta; terms_d.r21 = (wy - xz) <<< 1;
        terms_d.r31 = (yz + wx) <<< 1; terms_d.r32 = tc;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) terms_q <= terms_d;
  end

  assign terms_o = terms_q;

endmodule

FILE: sv/qtea_sqrt.sv
// Asin front end: clamps r21 to [-1,1] and forms sqrt(1 - r21^2) in a digit pipeline.
module qtea_sqrt (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [qtea_pkg::TERM_W-1:0]  r21_i,
  output logic signed [qtea_pkg::FRAC_W+1:0]  r21_o,
  output logic [qtea_pkg::FRAC_W:0]           root_o
);
  import qtea_pkg::*;

  localparam logic signed [TERM_W-1:0] ONE_T = TERM_W'(64'sd1 <<< FRAC_W);
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(64'd1 << (2 * FRAC_W));

  // The clamped term reaches +1 exactly, so it carries one bit above the fraction and sign.
  logic signed [FRAC_W+1:0]   clamp_q, sq_r21_q;
  logic signed [2*FRAC_W+3:0] sq_c;
  logic [SQ_W-1:0]            rad_q;
  logic [SQ_W-1:0]            rem_q  [ROOT_STAGES];
  logic [SQ_W-1:0]            root_q [ROOT_STAGES];
  logic signed [FRAC_W+1:0]   r21_q  [ROOT_STAGES];

  assign sq_c = clamp_q * clamp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (r21_i > ONE_T) clamp_q <= (FRAC_W + 2)'(ONE_T);
      else if (r21_i < -ONE_T) clamp_q <= (FRAC_W + 2)'(-ONE_T);
      else clamp_q <= (FRAC_W + 2)'(r21_i);
      sq_r21_q <= clamp_q;
      rad_q <= ONE_SQ - sq_c[SQ_W-1:0];
    end
  end

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_root
    logic [SQ_W-1:0] rem_in, root_in, rem_d, root_d;
    logic signed [FRAC_W+1:0] r21_in;
    if (s == 0) begin : g_first
      assign rem_in = rad_q;
      assign root_in = '0;
      assign r21_in = sq_r21_q;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign r21_in = r21_q[s-1];
    end

    always_comb begin
      logic [SQ_W-1:0] bitv, trial;
      rem_d = rem_in;
      root_d = root_in;
      for (int j = 0; j < ROOT_PER_STAGE; j++) begin
        if (s * ROOT_PER_STAGE + j < ROOT_STEPS) begin
          bitv = SQ_W'(1) << (2 * FRAC_W - 2 * (s * ROOT_PER_STAGE + j));
          trial = root_d + bitv;
          if (rem_d >= trial) begin
            rem_d = rem_d - trial;
            root_d = (root_d >> 1) + bitv;
          end else begin
            root_d = root_d >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        root_q[s] <= root_d;
        r21_q[s] <= r21_in;
      end
    end
  end

  assign root_o = root_q[ROOT_STAGES-1][FRAC_W:0];
  assign r21_o = r21_q[ROOT_STAGES-1];

endmodule

FILE: sv/qtea_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) with one iteration per stage.
module qtea_cordic #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [qtea_pkg::CORD_W-1:0] y_i,
  input  logic signed [qtea_pkg::CORD_W-1:0] x_i,
  output logic signed [ANGLE_WIDTH-1:0]      angle_o
);
  import qtea_pkg::*;

  localparam int RSH = ZUNIT_W - ANGLE_WIDTH;
  localparam logic signed [ZACC_W-1:0] QUARTER = ZACC_W'(64'sd1 <<< (ZUNIT_W - 2));

  logic signed [CORD_W-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CORD_W-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZACC_W-1:0] z_q [CORDIC_STAGES+1];
  logic                     zero_q [CORDIC_STAGES+1];
  logic signed [ANGLE_WIDTH-1:0] angle_q;

  // Vectors in the left half-plane are turned by a quarter turn first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0 && y_i >= 0) begin
        x_q[0] <= y_i; y_q[0] <= -x_i; z_q[0] <= QUARTER;
      end else if (x_i < 0) begin
        x_q[0] <= -y_i; y_q[0] <= x_i; z_q[0] <= -QUARTER;
      end else begin
        x_q[0] <= x_i; y_q[0] <= y_i; z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [ZACC_W-1:0] ATAN_I = ZACC_W'(ATAN_TAB[i]);
    logic signed [CORD_W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys; y_q[i+1] <= y_q[i] - xs; z_q[i+1] <= z_q[i] + ATAN_I;
        end else begin
          x_q[i+1] <= x_q[i] - ys; y_q[i+1] <= y_q[i] + xs; z_q[i+1] <= z_q[i] - ATAN_I;
        end
      end
    end
  end

  logic signed [ZACC_W-1:0] z_round, z_shift;
  if (RSH > 0) begin : g_round
    assign z_round = z_q[CORDIC_STAGES] + (ZACC_W'(1) <<< (RSH - 1));
  end else begin : g_exact
    assign z_round = z_q[CORDIC_STAGES];
  end
  assign z_shift = z_round >>> RSH;

  always_ff @(posedge clk_i) begin
    if (en_i) angle_q <= zero_q[CORDIC_STAGES] ? '0 : z_shift[ANGLE_WIDTH-1:0];
  end

  assign angle_o = angle_q;

endmodule

FILE: sv/quaternion_to_euler_angles.sv
// Top level of the quaternion to Tait-Bryan Euler angle converter.
// Converts a Q1.14 quaternion into three Tait-Bryan angles (2^(ANGLE_WIDTH-1) is pi) for the
// axis order held in rotation_sequence. The pipeline takes one item every cycle while the
// output is not stalled: two stages form the matrix terms, eighteen clamp r21 and take
// the square root two bits per stage, and each of three parallel CORDIC units spends one
// stage per iteration plus entry and rounding stages. A stall at the output freezes the
// whole pipeline.
module quaternion_to_euler_angles #(
  parameter int QUAT_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qtea_cfg_if.sink      cfg_i,
  qtea_quat_if.sink     quat_i,
  qtea_angle_if.source  angle_o
);
  import qtea_pkg::*;

  localparam int LAT = 2 + SQRT_LAT + CORDIC_STAGES + 2;

  logic             en, in_acc;
  logic [SEQ_W-1:0] seq_q;
  logic [LAT-1:0]   valid_q, valid_d;
  terms_t           terms;
  terms_t           dly_q [SQRT_LAT];
  logic signed [FRAC_W+1:0] r21_c;
  logic [FRAC_W:0]          root;
  logic signed [ANGLE_WIDTH-1:0] ang_third, ang_second, ang_first;

  assign en = !valid_q[LAT-1] || angle_o.ready;
  assign quat_i.ready = en;
  assign in_acc = quat_i.valid && en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_ZYX;
    end else if (cfg_i.valid) begin
      seq_q <= cfg_i.rotation_sequence;
    end
  end

  assign valid_d = {valid_q[LAT-2:0], in_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  qtea_terms #(.QUAT_WIDTH(QUAT_WIDTH)) u_terms (
    .clk_i    (clk_i),
    .en_i     (en),
    .seq_i    (seq_q),
    .quat_w_i (quat_i.quat_w),
    .quat_x_i (quat_i.quat_x),
    .quat_y_i (quat_i.quat_y),
    .quat_z_i (quat_i.quat_z),
    .terms_o  (terms)
  );

  qtea_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .r21_i  (terms.r21),
    .r21_o  (r21_c),
    .root_o (root)
  );

  // The two atan2 pairs wait beside the square root pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= terms;
      for (int k = 1; k < SQRT_LAT; k++) dly_q[k] <= dly_q[k-1];
    end
  end

  qtea_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_third (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (CORD_W'(dly_q[SQRT_LAT-1].r31)),
    .x_i     (CORD_W'(dly_q[SQRT_LAT-1].r32)),
    .angle_o (ang_third)
  );

  qtea_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_second (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (CORD_W'(r21_c)),
    .x_i     (CORD_W'(signed'({1'b0, root}))),
    .angle_o (ang_second)
  );

  qtea_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_first (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (CORD_W'(dly_q[SQRT_LAT-1].r11)),
    .x_i     (CORD_W'(dly_q[SQRT_LAT-1].r12)),
    .angle_o (ang_first)
  );

  assign angle_o.valid = valid_q[LAT-1];
  assign angle_o.angle_third_axis = ang_third;
  assign angle_o.angle_second_axis = ang_second;
  assign angle_o.angle_first_axis = ang_first;

`ifndef SYNTHESIS
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat_i.ready == (!angle_o.valid || angle_o.ready))
    else $error("input ready does not follow the output stage");

  a_stall_freezes_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("valid bits moved during a stall");

  a_empty_stays_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q == '0 && !in_acc) |=> !angle_o.valid)
    else $error("result appeared from an empty pipeline");
`endif

endmodule
